>>> hw/rtl/csrmv_pkg.sv
// ----------------------------------------------------------------------------
// csrmv_pkg
// Shared widths, request codes and control types for the CSR sparse
// matrix-vector multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package csrmv_pkg;

   // field widths
   localparam int COL_WIDTH   = 10;
   localparam int VALUE_WIDTH = 32;
   localparam int SUM_WIDTH   = 64;
   localparam int ROW_WIDTH   = 16;

   // parameter defaults
   localparam int VEC_DEPTH_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT  = 65536;

   // request codes
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_ENTRY   = 2'd1;
   localparam logic [1:0] REQ_ROW_END = 2'd2;

   // pipeline control handed to the multiply-accumulate unit
   typedef struct packed {
      logic advance;
      logic s1_entry;
      logic s1_in_range;
      logic s2_entry;
      logic s2_row_end;
   } mac_ctrl_type;

endpackage

`default_nettype wire

>>> hw/rtl/csrmv_ram.sv
// ----------------------------------------------------------------------------
// csrmv_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csrmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/csrmv_mac.sv
// ----------------------------------------------------------------------------
// csrmv_mac
// Product register and saturating row accumulator: multiplies a matrix value
// by the vector element read from the store, then adds into the row sum.
// ----------------------------------------------------------------------------
`default_nettype none

module csrmv_mac (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire csrmv_pkg::mac_ctrl_type                  ctrl,
   input  wire logic signed [csrmv_pkg::VALUE_WIDTH-1:0] value,
   input  wire logic        [csrmv_pkg::VALUE_WIDTH-1:0] vec_data,
   output logic signed      [csrmv_pkg::SUM_WIDTH-1:0]   acc_sum,
   output logic                                          acc_ovf
);
   import csrmv_pkg::*;

   localparam logic [SUM_WIDTH-1:0] SatMax = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SatMin = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   logic signed [VALUE_WIDTH-1:0] vec_sel;
   logic signed [SUM_WIDTH-1:0]   prod_in, prod_ff;
   logic signed [SUM_WIDTH-1:0]   acc_in, acc_ff;
   logic                          ovf_in, ovf_ff;
   logic        [SUM_WIDTH-1:0]   raw_sum;
   logic                          same_sign, flipped;

   // multiply; a column beyond the store reads as zero
   always_comb begin
      vec_sel = ctrl.s1_in_range ? $signed(vec_data) : '0;
      prod_in = prod_ff;
      if (ctrl.advance && ctrl.s1_entry) begin
         prod_in = value * vec_sel;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // saturating accumulate, clear on row end
   always_comb begin
      raw_sum   = acc_ff + prod_ff;
      same_sign = (acc_ff[SUM_WIDTH-1] == prod_ff[SUM_WIDTH-1]);
      flipped   = (raw_sum[SUM_WIDTH-1] != acc_ff[SUM_WIDTH-1]);
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      if (ctrl.advance) begin
         priority if (ctrl.s2_row_end) begin
            acc_in = '0;
            ovf_in = 1'b0;
         end else if (ctrl.s2_entry) begin
            if (same_sign && flipped) begin
               acc_in = acc_ff[SUM_WIDTH-1] ? SatMin : SatMax;
               ovf_in = 1'b1;
            end else begin
               acc_in = raw_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   assign acc_sum = acc_ff;
   assign acc_ovf = ovf_ff;

endmodule

`default_nettype wire

>>> hw/rtl/csr_sparse_matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply_top
// Streaming sparse matrix times dense vector in compressed-sparse-row order.
// ----------------------------------------------------------------------------
// Load the dense vector first with load requests, then send each row's nonzero
// entries followed by an end-of-row request. The block takes one request per
// clock while req_stall is low. A request runs through three stages: the
// vector store (a synchronous RAM with registered read) is read or written
// on the transfer, the 32x32 product is registered next, and the 64-bit
// saturating add or the row result follows. A row sum lands in the result
// register after its end-of-row has passed the s1 and s2 stage flags. Input
// stalls only while an end-of-row reaches the last stage and the result
// register still holds an untaken sum. Vector elements need no initialization
// pass; reading an element that was never loaded gives an undefined product.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply_top #(
   parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEFAULT,
   parameter int MAX_ROWS  = csrmv_pkg::MAX_ROWS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic        [1:0]                        req_type,
   input  wire logic        [csrmv_pkg::COL_WIDTH-1:0]   req_col_index,
   input  wire logic signed [csrmv_pkg::VALUE_WIDTH-1:0] req_entry_value,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed      [csrmv_pkg::SUM_WIDTH-1:0]   rsp_row_sum,
   output logic             [csrmv_pkg::ROW_WIDTH-1:0]   rsp_row_index,
   output logic                                          rsp_saturated
);
   import csrmv_pkg::*;

   localparam int AddrWidth = $clog2(VEC_DEPTH > 1 ? VEC_DEPTH : 2);
   localparam logic [ROW_WIDTH:0] DepthLimit = (ROW_WIDTH+1)'(VEC_DEPTH);
   localparam logic [ROW_WIDTH:0] RowLimit   = (ROW_WIDTH+1)'(MAX_ROWS);

   logic                          advance, accept;
   logic [ROW_WIDTH:0]            col_wide;
   logic                          in_range;
   logic [AddrWidth-1:0]          addr;
   logic [VALUE_WIDTH-1:0]        vec_data;
   mac_ctrl_type                  mac_ctrl;
   logic signed [SUM_WIDTH-1:0]   acc_sum;
   logic                          acc_ovf;

   logic                          s1_entry_in, s1_entry_ff;
   logic                          s1_row_end_in, s1_row_end_ff;
   logic                          s1_in_range_in, s1_in_range_ff;
   logic signed [VALUE_WIDTH-1:0] s1_value_in, s1_value_ff;
   logic                          s2_entry_in, s2_entry_ff;
   logic                          s2_row_end_in, s2_row_end_ff;
   logic                          rsp_valid_in, rsp_valid_ff;
   logic signed [SUM_WIDTH-1:0]   rsp_sum_in, rsp_sum_ff;
   logic                          rsp_sat_in, rsp_sat_ff;
   logic [ROW_WIDTH-1:0]          rsp_row_in, rsp_row_ff;
   logic [ROW_WIDTH-1:0]          row_cnt_in, row_cnt_ff;
   logic [ROW_WIDTH:0]            row_next;

   // freeze the pipe only when a row end meets a held result
   assign advance   = !(s2_row_end_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // decode the store address
   assign col_wide = (ROW_WIDTH+1)'(req_col_index);
   assign in_range = (col_wide < DepthLimit);
   assign addr     = col_wide[AddrWidth-1:0];

   csrmv_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (VEC_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (accept && (req_type == REQ_LOAD) && in_range),
      .wr_addr (addr),
      .wr_data (req_entry_value),
      .rd_en   (accept && (req_type == REQ_ENTRY)),
      .rd_addr (addr),
      .rd_data (vec_data)
   );

   // advance the stage flags; loads and unused codes leave a bubble
   always_comb begin
      s1_entry_in    = s1_entry_ff;
      s1_row_end_in  = s1_row_end_ff;
      s1_in_range_in = s1_in_range_ff;
      s1_value_in    = s1_value_ff;
      s2_entry_in    = s2_entry_ff;
      s2_row_end_in  = s2_row_end_ff;
      if (advance) begin
         s1_entry_in    = accept && (req_type == REQ_ENTRY);
         s1_row_end_in  = accept && (req_type == REQ_ROW_END);
         s1_in_range_in = in_range;
         s1_value_in    = req_entry_value;
         s2_entry_in    = s1_entry_ff;
         s2_row_end_in  = s1_row_end_ff;
      end
   end

   assign mac_ctrl = '{advance:     advance,
                       s1_entry:    s1_entry_ff,
                       s1_in_range: s1_in_range_ff,
                       s2_entry:    s2_entry_ff,
                       s2_row_end:  s2_row_end_ff};

   csrmv_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .value    (s1_value_ff),
      .vec_data (vec_data),
      .acc_sum  (acc_sum),
      .acc_ovf  (acc_ovf)
   );

   // capture the row result and step the row counter
   always_comb begin
      row_next     = (ROW_WIDTH+1)'(row_cnt_ff) + 1'b1;
      row_cnt_in   = row_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_row_in   = rsp_row_ff;
      if (advance && s2_row_end_ff) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc_sum;
         rsp_sat_in   = acc_ovf;
         rsp_row_in   = row_cnt_ff;
         row_cnt_in   = (row_next >= RowLimit) ? '0 : row_next[ROW_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_entry_ff   <= 1'b0;
         s1_row_end_ff <= 1'b0;
         s2_entry_ff   <= 1'b0;
         s2_row_end_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_cnt_ff    <= '0;
      end else begin
         s1_entry_ff   <= s1_entry_in;
         s1_row_end_ff <= s1_row_end_in;
         s2_entry_ff   <= s2_entry_in;
         s2_row_end_ff <= s2_row_end_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_cnt_ff    <= row_cnt_in;
      end
      s1_in_range_ff <= s1_in_range_in;
      s1_value_ff    <= s1_value_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_sat_ff     <= rsp_sat_in;
      rsp_row_ff     <= rsp_row_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_sum   = rsp_sum_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_saturated = rsp_sat_ff;

   // a finished row leaves a cleared accumulator behind
   assert property (@(posedge clock) disable iff (reset)
      (advance && s2_row_end_ff) |=> (acc_sum == '0 && !acc_ovf))
      else $error("accumulator not cleared after row end");

   // a frozen pipe keeps its row end in the last stage
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> s2_row_end_ff)
      else $error("row end lost while stalled");

   // a row result always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      (advance && s2_row_end_ff) |=> rsp_valid_ff)
      else $error("row result not captured");

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming CSR sparse matrix-vector multiply.
// A short directed list covers the empty row, both saturation directions,
// a vector reload in the middle of a row and the unused request code.
// After that, random rows of nonzero entries run against an in-bench Q32.32
// predictor. Both handshakes idle and stall at random. One long receiver
// hold-off fills the pipeline, and a full drain mid-run empties it.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import csrmv_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int IDLE_LIMIT     = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int DIRECTED_COUNT = 25;

   localparam logic [1:0]  REQ_UNUSED = 2'd3;
   localparam logic [63:0] SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SUM_MIN    = 64'h8000_0000_0000_0000;
   localparam logic [31:0] Q_MIN      = 32'h8000_0000;
   localparam logic [31:0] Q_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_ONE      = 32'h0001_0000;
   localparam logic [31:0] Q_TWO      = 32'h0002_0000;
   localparam logic [31:0] Q_NEG_ONE  = 32'hFFFF_0000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] sum;
      logic [ROW_WIDTH-1:0] index;
      logic                 saturated;
   } row_result_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [COL_WIDTH-1:0]   col;
      logic [VALUE_WIDTH-1:0] value;
      logic                   typed;
      row_result_type         want;
   } directed_row_type;

   // DUT ports
   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_type        = REQ_LOAD;
   logic [COL_WIDTH-1:0]          req_col_index   = '0;
   logic signed [VALUE_WIDTH-1:0] req_entry_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic signed [SUM_WIDTH-1:0]   rsp_row_sum;
   logic [ROW_WIDTH-1:0]          rsp_row_index;
   logic                          rsp_saturated;

   // predictor state
   logic signed [VALUE_WIDTH-1:0] shadow_vector [VEC_DEPTH_DEFAULT];
   logic signed [SUM_WIDTH-1:0]   shadow_sum      = '0;
   logic                          shadow_overflow = 1'b0;
   logic [ROW_WIDTH-1:0]          next_row        = '0;

   // expected row sums, oldest first
   row_result_type row_sums_expected [$];

   // stimulus bookkeeping
   bit                   col_loaded [VEC_DEPTH_DEFAULT];
   logic [COL_WIDTH-1:0] loaded_cols [$];
   int                   items_sent       = 0;
   int                   ignored_sent     = 0;
   int                   burst_left       = 0;
   int                   hold_off_request = 0;

   // checker tallies
   int failures       = 0;
   int rows_checked   = 0;
   int saturated_rows = 0;
   int idle_cycles    = 0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // empty row straight after reset
      '{REQ_ROW_END, 10'd0,    32'h0, 1'b1, '{64'd0, 16'd0, 1'b0}},
      '{REQ_LOAD,    10'd0,    Q_MIN, 1'b0, '0},
      '{REQ_LOAD,    10'd1023, Q_MAX, 1'b0, '0},
      '{REQ_LOAD,    10'd1,    Q_ONE, 1'b0, '0},
      // two 2^62 products overflow upward, then continue from the clamp
      '{REQ_ENTRY,   10'd0,    Q_MIN, 1'b0, '0},
      '{REQ_ENTRY,   10'd0,    Q_MIN, 1'b0, '0},
      '{REQ_ENTRY,   10'd1,    Q_ONE, 1'b0, '0},
      '{REQ_ROW_END, 10'd1023, Q_MAX, 1'b1, '{SUM_MAX, 16'd1, 1'b1}},
      // three large negative products clamp downward
      '{REQ_ENTRY,   10'd1023, Q_MIN, 1'b0, '0},
      '{REQ_ENTRY,   10'd1023, Q_MIN, 1'b0, '0},
      '{REQ_ENTRY,   10'd1023, Q_MIN, 1'b0, '0},
      '{REQ_ROW_END, 10'd0,    32'h0, 1'b1, '{SUM_MIN, 16'd2, 1'b1}},
      // reload inside a row leaves the running sum alone
      '{REQ_ENTRY,   10'd1,    Q_ONE,     1'b0, '0},
      '{REQ_LOAD,    10'd1,    Q_NEG_ONE, 1'b0, '0},
      '{REQ_ENTRY,   10'd1,    Q_TWO,     1'b0, '0},
      '{REQ_UNUSED,  10'd1,    Q_MAX,     1'b0, '0},
      '{REQ_ROW_END, 10'd0,    32'h0, 1'b1, '{64'hFFFF_FFFF_0000_0000, 16'd3, 1'b0}},
      // mixed signs near full scale, flag cleared from the last row
      '{REQ_ENTRY,   10'd0,    Q_MAX, 1'b0, '0},
      '{REQ_ENTRY,   10'd1023, Q_MAX, 1'b0, '0},
      '{REQ_ROW_END, 10'd0,    32'h0, 1'b0, '0},
      '{REQ_ROW_END, 10'd1023, Q_MAX, 1'b1, '{64'd0, 16'd5, 1'b0}},
      '{REQ_LOAD,    10'd512,  32'h5555_AAAA, 1'b0, '0},
      '{REQ_LOAD,    10'd682,  32'hAAAA_5555, 1'b0, '0},
      '{REQ_ENTRY,   10'd512,  32'hAAAA_5555, 1'b0, '0},
      '{REQ_ROW_END, 10'd0,    32'h0, 1'b0, '0}
   };

   csr_sparse_matrix_vector_multiply_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_col_index   (req_col_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_row_sum     (rsp_row_sum),
      .rsp_row_index   (rsp_row_index),
      .rsp_saturated   (rsp_saturated)
   );

   always #CLOCK_HALF clock = ~clock;

   // Advance the shadow state by one request; queue the row sum on row end.
   function automatic void predict_spmv(input logic [1:0] kind,
                                        input logic [COL_WIDTH-1:0] col,
                                        input logic signed [VALUE_WIDTH-1:0] value);
      logic signed [SUM_WIDTH-1:0] lhs;
      logic signed [SUM_WIDTH-1:0] rhs;
      logic signed [SUM_WIDTH-1:0] product;
      logic signed [SUM_WIDTH-1:0] total;
      case (kind)
         REQ_LOAD: begin
            shadow_vector[col] = value;
         end
         REQ_ENTRY: begin
            lhs     = value;
            rhs     = shadow_vector[col];
            product = lhs * rhs;
            total   = shadow_sum + product;
            // same-sign operands whose sum flips sign have overflowed
            if (shadow_sum[63] == product[63] && total[63] != shadow_sum[63]) begin
               shadow_sum      = shadow_sum[63] ? SUM_MIN : SUM_MAX;
               shadow_overflow = 1'b1;
            end else begin
               shadow_sum = total;
            end
         end
         REQ_ROW_END: begin
            row_sums_expected.push_back('{shadow_sum, next_row, shadow_overflow});
            shadow_sum      = '0;
            shadow_overflow = 1'b0;
            next_row        = next_row + 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   // Pick a Q16.16 value, biased toward full scale and small magnitudes.
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return Q_MIN;
         1:       return Q_MAX;
         2:       return 32'($urandom_range(0, 32'h0003_FFFF));
         3:       return -32'($urandom_range(1, 32'h0003_FFFF));
         default: return $urandom();
      endcase
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [1:0] kind,
                               input logic [COL_WIDTH-1:0] col,
                               input logic [VALUE_WIDTH-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_col_index   <= col;
      req_entry_value <= value;
      do @(posedge clock); while (req_stall);
      predict_spmv(kind, col, value);
      if (kind == REQ_UNUSED) begin
         ignored_sent++;
      end else begin
         items_sent++;
      end
      if (kind == REQ_LOAD && !col_loaded[col]) begin
         col_loaded[col] = 1'b1;
         loaded_cols.push_back(col);
      end
   endtask

   // Drop valid and hold until every expected row sum has arrived.
   task automatic wait_for_row_sums();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (row_sums_expected.size() != 0);
   endtask

   task automatic send_random_load();
      send_request(REQ_LOAD, 10'($urandom_range(0, 1023)), pick_value());
   endtask

   task automatic send_random_entry();
      send_request(REQ_ENTRY, loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
                   pick_value());
   endtask

   // Receiver: change stall style now and then, and honor hold-off requests.
   initial begin : rsp_side
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      int             hold_seen;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request != hold_seen) begin
            hold_seen = hold_off_request;
            hold_left = HOLD_OFF_LEN;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 3) != 0);
               STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Compare each transfer on the result side with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      row_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (row_sums_expected.size() == 0) begin
            $error("unexpected row sum %h for row %0d", rsp_row_sum, rsp_row_index);
            failures++;
         end else begin
            want = row_sums_expected.pop_front();
            if (rsp_row_sum !== want.sum) begin
               $error("row_sum: expected %h, got %h", want.sum, rsp_row_sum);
               failures++;
            end
            if (rsp_row_index !== want.index) begin
               $error("row_index: expected %0d, got %0d", want.index, rsp_row_index);
               failures++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_saturated);
               failures++;
            end
            rows_checked++;
            if (want.saturated) saturated_rows++;
         end
      end
   end

   // End the run when neither side has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int  random_first;
      int  pick;
      bit  hold_off_done;
      bit  drain_done;
      hold_off_done = 1'b0;
      drain_done    = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed list; typed rows replace the predicted sum
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].kind, directed_rows[i].col, directed_rows[i].value);
         if (directed_rows[i].typed)
            row_sums_expected[row_sums_expected.size() - 1] = directed_rows[i].want;
      end

      // random rows with loads and unused codes mixed in
      random_first = items_sent;
      while (items_sent - random_first < RANDOM_ITEMS) begin
         if (!hold_off_done && items_sent - random_first > 400) begin
            // stall the receiver and offer 40 row ends so that the input backs up
            hold_off_request++;
            repeat (40) send_request(REQ_ROW_END, 10'($urandom_range(0, 1023)), $urandom());
            hold_off_done = 1'b1;
         end
         if (!drain_done && items_sent - random_first > 900) begin
            wait_for_row_sums();
            drain_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 6)) send_random_load();
         end else if (pick < 16) begin
            send_request(REQ_UNUSED, 10'($urandom_range(0, 1023)), $urandom());
         end else begin
            repeat ($urandom_range(0, 10)) begin
               if ($urandom_range(0, 19) == 0) send_random_load();
               if ($urandom_range(0, 29) == 0)
                  send_request(REQ_UNUSED, 10'($urandom_range(0, 1023)), $urandom());
               send_random_entry();
            end
            send_request(REQ_ROW_END, 10'($urandom_range(0, 1023)), $urandom());
         end
      end

      // drain, then give any stray result time to show up
      wait_for_row_sums();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests plus %0d unused codes; %0d vector slots loaded",
               items_sent, ignored_sent, loaded_cols.size());
      $display("Checked %0d row sums, %0d of them saturated",
               rows_checked, saturated_rows);
      if (failures == 0 && row_sums_expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
